>>> rtl/core/hamiltonian_cycle_search_unit_defines.svh
// assertion macros for the hamiltonian cycle search unit
// no dependencies; included by the modules that carry assertions
`ifndef HAMILTONIAN_CYCLE_SEARCH_UNIT_DEFINES_SVH
`define HAMILTONIAN_CYCLE_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define HCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcs assertion failed");

// next-cycle implication
`define HCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcs assertion failed");

`endif

>>> rtl/core/hcs_pkg.sv
// shared constants for the hamiltonian cycle search unit
// no dependencies
`timescale 1ns / 1ps

package hcs_pkg;

   localparam int DEF_NUM_VERTICES = 8;

   // item field widths
   localparam int ROW_INDEX_WIDTH = 3;
   localparam int ROW_WIDTH       = 8;
   localparam int VERTEX_WIDTH    = 3;

   // adjacency storage has one slot per loadable row
   localparam int ROW_SLOTS       = 8;

endpackage

>>> rtl/core/hamiltonian_cycle_search_unit.sv
// Hamiltonian cycle search unit. Rows of a directed adjacency matrix are loaded one item per
// cycle (start high while busy is low); the item with req_last_row set also starts a
// depth-first backtracking search from vertex 0. Each search step either extends the path
// by one vertex or backs out of one depth: all vertices are checked at once by one lane
// each and the lowest free neighbor is taken, so the search time is data dependent. On
// success NUM_VERTICES + 1 results follow back to back (the cycle, then vertex 0 again,
// found set, last on the final one); on failure a single result with found clear and last
// set. Results appear for one cycle under rsp_valid and cannot be held off; busy stays
// high from the search until the last result. Rows persist across searches; every row up
// to NUM_VERTICES - 1 must be loaded before the first search.
// depends on hcs_pkg, hcs_lane, hcs_merge and hamiltonian_cycle_search_unit_defines.svh
`timescale 1ns / 1ps
`include "hamiltonian_cycle_search_unit_defines.svh"

module hamiltonian_cycle_search_unit #(
   parameter int NUM_VERTICES = hcs_pkg::DEF_NUM_VERTICES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hcs_pkg::ROW_INDEX_WIDTH-1:0] req_row_index,
   input  logic [hcs_pkg::ROW_WIDTH-1:0]       req_row_edges,
   input  logic                                req_last_row,
   output logic                                rsp_valid,
   output logic [hcs_pkg::VERTEX_WIDTH-1:0]    rsp_vertex,
   output logic                                rsp_found,
   output logic                                rsp_last
);

   localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int DW = $clog2(NUM_VERTICES + 1);
   localparam logic [NUM_VERTICES-1:0] ONE_HOT0 = NUM_VERTICES'(1);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(NUM_VERTICES);

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [DW-1:0]             depth_ff, depth_in;
   logic [DW-1:0]             try_ff, try_in;
   logic [VW-1:0]             prev_ff, prev_in;
   logic [NUM_VERTICES-1:0]   visited_ff, visited_in;
   logic [DW-1:0]             emit_ff, emit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [hcs_pkg::VERTEX_WIDTH-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [VW-1:0]             path_ff [NUM_VERTICES];
   logic [hcs_pkg::ROW_WIDTH-1:0] adj_ff [hcs_pkg::ROW_SLOTS];

   logic                      path_we;
   logic [VW-1:0]             path_rd_addr;
   logic [VW-1:0]             path_rd;
   logic [31:0]               path_rd_wide;
   logic [DW-1:0]             depth_m2;
   logic                      adj_we;
   logic                      row_in_range;
   logic [31:0]               prev_wide;
   logic [hcs_pkg::ROW_WIDTH-1:0] row_sel;
   logic [NUM_VERTICES-1:0]   edge_vec;
   logic [NUM_VERTICES-1:0]   candidates;
   logic                      hit;
   logic [VW-1:0]             pick;
   logic                      at_full, at_root, do_close, do_adv, accept;

   assign accept       = start && (state_ff == ST_LOAD);
   assign row_in_range = 32'(req_row_index) < 32'(NUM_VERTICES);
   assign adj_we       = accept && row_in_range;

   // row of the current path tail; rows past the stored slots have no edges
   assign prev_wide = 32'(prev_ff);
   assign row_sel   = (prev_wide < 32'(hcs_pkg::ROW_SLOTS)) ? adj_ff[prev_wide[2:0]] : '0;

   for (genvar v = 0; v < NUM_VERTICES; v++) begin : g_lane
      if (v < hcs_pkg::ROW_WIDTH) begin : g_edge
         assign edge_vec[v] = row_sel[v];
      end else begin : g_no_edge
         assign edge_vec[v] = 1'b0;
      end

      hcs_lane #(
         .LANE_ID   (v),
         .TRY_WIDTH (DW)
      ) u_lane (
         .try_from  (try_ff),
         .visited   (visited_ff[v]),
         .edge_bit  (edge_vec[v]),
         .candidate (candidates[v])
      );
   end

   hcs_merge #(
      .NUM_VERTICES (NUM_VERTICES),
      .IDX_WIDTH    (VW)
   ) u_merge (
      .candidates (candidates),
      .hit        (hit),
      .pick       (pick)
   );

   // single path read port: the vertex below the tail while searching, the output while emitting
   assign depth_m2 = depth_ff - DW'(2);
   always_comb begin
      if (state_ff == ST_EMIT) begin
         path_rd_addr = (emit_ff == DEPTH_FULL) ? '0 : emit_ff[VW-1:0];
      end else begin
         path_rd_addr = depth_m2[VW-1:0];
      end
   end
   // slot 0 is always the root vertex 0
   assign path_rd      = (path_rd_addr == '0) ? '0 : path_ff[path_rd_addr];
   assign path_rd_wide = 32'(path_rd);

   assign at_full  = depth_ff == DEPTH_FULL;
   assign at_root  = depth_ff == DW'(1);
   assign do_close = at_full && row_sel[0];
   assign do_adv   = !at_full && hit;

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      try_in        = try_ff;
      prev_in       = prev_ff;
      visited_in    = visited_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      path_we       = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_row) begin
               state_in   = ST_SEARCH;
               depth_in   = DW'(1);
               try_in     = DW'(1);
               prev_in    = '0;
               visited_in = ONE_HOT0;
            end
         end
         ST_SEARCH: begin
            if (do_close) begin
               state_in = ST_EMIT;
               emit_in  = '0;
            end else if (do_adv) begin
               path_we    = 1'b1;
               visited_in = visited_ff | (ONE_HOT0 << pick);
               depth_in   = depth_ff + DW'(1);
               prev_in    = pick;
               try_in     = DW'(1);
            end else if (at_root) begin
               // every branch exhausted: no cycle
               state_in      = ST_LOAD;
               depth_in      = '0;
               visited_in    = '0;
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b1;
            end else begin
               // back out of the tail, resume the level below after it
               visited_in = visited_ff & ~(ONE_HOT0 << prev_ff);
               depth_in   = depth_ff - DW'(1);
               try_in     = DW'(prev_ff) + DW'(1);
               prev_in    = path_rd;
            end
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = path_rd_wide[hcs_pkg::VERTEX_WIDTH-1:0];
            rsp_found_in  = 1'b1;
            rsp_last_in   = emit_ff == DEPTH_FULL;
            if (emit_ff == DEPTH_FULL) begin
               state_in   = ST_LOAD;
               depth_in   = '0;
               visited_in = '0;
            end else begin
               emit_in = emit_ff + DW'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         depth_ff     <= '0;
         try_ff       <= '0;
         prev_ff      <= '0;
         visited_ff   <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         try_ff       <= try_in;
         prev_ff      <= prev_in;
         visited_ff   <= visited_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_ff[depth_ff[VW-1:0]] <= pick;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_ff[req_row_index] <= req_row_edges;
      end
   end

   assign busy       = state_ff != ST_LOAD;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_last   = rsp_last_ff;

   `HCS_ASSERT_NOW(a_depth_range, clock, reset, state_ff == ST_SEARCH, depth_ff <= DEPTH_FULL)
   `HCS_ASSERT_NOW(a_visited_count, clock, reset, state_ff == ST_SEARCH, $countones(visited_ff) == int'(depth_ff))
   `HCS_ASSERT_NOW(a_root_visited, clock, reset, state_ff == ST_SEARCH, visited_ff[0])
   `HCS_ASSERT_NOW(a_last_idles, clock, reset, rsp_valid_ff && rsp_last_ff, state_ff == ST_LOAD)
   `HCS_ASSERT_NEXT(a_last_row_starts, clock, reset, start && !busy && req_last_row, state_ff == ST_SEARCH)

endmodule

>>> rtl/core/hcs_lane.sv
// one candidate-check lane: decides whether its vertex can extend the path
// depends on nothing; instantiated once per vertex by the top level
`timescale 1ns / 1ps

module hcs_lane #(
   parameter int LANE_ID   = 0,
   parameter int TRY_WIDTH = 4
) (
   input  logic [TRY_WIDTH-1:0] try_from,
   input  logic                 visited,
   input  logic                 edge_bit,
   output logic                 candidate
);

   localparam logic [TRY_WIDTH-1:0] LANE_VALUE = TRY_WIDTH'(LANE_ID);

   // only vertices at or above the resume point count at this depth
   assign candidate = (LANE_VALUE >= try_from) && !visited && edge_bit;

endmodule

>>> rtl/core/hcs_merge.sv
// merging stage: lowest-index candidate over all lanes
// depends on nothing; instantiated by the top level
`timescale 1ns / 1ps

module hcs_merge #(
   parameter int NUM_VERTICES = 8,
   parameter int IDX_WIDTH    = 3
) (
   input  logic [NUM_VERTICES-1:0] candidates,
   output logic                    hit,
   output logic [IDX_WIDTH-1:0]    pick
);

   always_comb begin
      hit  = 1'b0;
      pick = '0;
      // walk downward so the lowest set lane wins
      for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
         if (candidates[i]) begin
            hit  = 1'b1;
            pick = IDX_WIDTH'(i);
         end
      end
   end

endmodule
